/* hdl/mst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multi-slot timer
// Command, result and status codes, the controller state type and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mst_pkg;

	// Default number of timer slots.
	localparam int SLOTS_DEF = 16;

	// Most firings reported by one tick; the scan stops after the last of them.
	localparam int MAX_RESULTS = 16;
	localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SET     = 3'd1,
		CMD_DELETE  = 3'd2,
		CMD_RESTART = 3'd3,
		CMD_ENABLE  = 3'd4,
		CMD_DISABLE = 3'd5,
		CMD_TOGGLE  = 3'd6,
		CMD_QUERY   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_FIRED = 2'd0,
		KIND_IDLE  = 2'd1,
		KIND_ACK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_NULL   = 2'd2,
		STAT_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_SCAN  = 2'd2,
		ST_FLUSH = 2'd3
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // latch the input word
		logic exec;   // execute a single-slot command
		logic scan;   // run the tick scan pipeline
		logic flush;  // close the tick and report its final word
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;    // the offered command is a tick
		logic scan_done;  // the scan has evaluated its final slot or its last allowed firing
	} sts_t;

endpackage

/* hdl/mst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_ctrl: controller of the multi-slot timer
// Sequences one input word at a time through execute or scan and flush.
// ----------------------------------------------------------------------------
module mst_ctrl import mst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = sts.is_tick ? ST_SCAN : ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_EXEC:  ctl.exec = 1'b1;
			ST_SCAN:  ctl.scan = 1'b1;
			ST_FLUSH: ctl.flush = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

/* hdl/mst_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_dpath: datapath of the multi-slot timer
// Slot tables, occupancy and enable flags, the two-stage scan pipeline,
// the held-back firing word and the result registers.
// ----------------------------------------------------------------------------
module mst_dpath import mst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [2:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [5:0]  slot,
	input  logic [30:0] period_ms,
	input  logic [15:0] run_limit,
	input  logic [7:0]  handler,
	output logic        res_valid,
	output logic [1:0]  kind,
	output logic [5:0]  out_slot,
	output logic [7:0]  out_handler,
	output logic        freed,
	output logic [1:0]  status,
	output logic        is_enabled,
	output logic [6:0]  active_count,
	output logic        last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Latched input word.
	cmd_t        cmd_q;
	logic [31:0] now_q;
	logic [5:0]  slot_q;
	logic [30:0] period_q;
	logic [15:0] limit_q;
	logic [7:0]  handler_q;

	// Occupancy, enable flags and the occupied count.
	logic [SLOTS-1:0] used_q, used_d;
	logic [SLOTS-1:0] en_q, en_d;
	logic [6:0]       cnt_q, cnt_d;

	// Slot tables.
	logic [30:0] period_mem  [SLOTS];
	logic [15:0] limit_mem   [SLOTS];
	logic [7:0]  handler_mem [SLOTS];
	logic [15:0] runs_mem    [SLOTS];
	logic [31:0] base_mem    [SLOTS];

	// Scan pipeline.
	logic [CW-1:0]     rd_idx_q;
	logic              rd_more;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic              ev_v_s1;
	logic [IW-1:0]     ev_idx_s1;
	logic [30:0]       period_s1;
	logic [15:0]       limit_s1;
	logic [7:0]        handler_s1;
	logic [15:0]       runs_s1;
	logic [31:0]       base_s1;
	logic [FIRE_W-1:0] fire_cnt_q;

	// Evaluation of the slot in the second stage.
	logic        ev_on;
	logic [31:0] elapsed;
	logic [31:0] base_sum;
	logic [15:0] runs_inc;
	logic        unlimited;
	logic        ev_due;
	logic        ev_fire;
	logic        ev_last;

	// Held-back firing word.
	logic          pend_v_q;
	logic [IW-1:0] pend_slot_q;
	logic [7:0]    pend_handler_q;
	logic          pend_freed_q;
	logic [6:0]    pend_count_q;

	// Single-slot command decode.
	logic          in_range;
	logic [IW-1:0] tgt;
	logic          any_free;
	logic [IW-1:0] free_idx;

	// Table write port.
	logic [IW-1:0] waddr;
	logic          we_cfg;
	logic          we_runs;
	logic          we_base;
	logic [15:0]   wd_runs;
	logic [31:0]   wd_base;

	// Result word being formed.
	logic       emit;
	kind_t      e_kind;
	logic [5:0] e_slot;
	logic [7:0] e_handler;
	logic       e_freed;
	status_t    e_status;
	logic       e_en;
	logic [6:0] e_count;
	logic       e_last;

	kind_t      kind_q;
	status_t    status_q;
	logic       valid_q;
	logic [5:0] out_slot_q;
	logic [7:0] out_handler_q;
	logic       freed_q;
	logic       en_out_q;
	logic [6:0] count_q;
	logic       last_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= cmd_t'(cmd);
			now_q     <= now_ms;
			slot_q    <= slot;
			period_q  <= period_ms;
			limit_q   <= run_limit;
			handler_q <= handler;
		end
	end

	assign in_range = {1'b0, slot_q} < 7'(SLOTS);
	assign tgt      = slot_q[IW-1:0];

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign rd_more = rd_idx_q < CW'(SLOTS);
	assign rd_en   = ctl.scan && rd_more;
	assign rd_addr = rd_idx_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (we_cfg) begin
			period_mem[waddr]  <= period_q;
			limit_mem[waddr]   <= limit_q;
			handler_mem[waddr] <= handler_q;
		end
		if (we_runs) begin
			runs_mem[waddr] <= wd_runs;
		end
		if (we_base) begin
			base_mem[waddr] <= wd_base;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			period_s1  <= period_mem[rd_addr];
			limit_s1   <= limit_mem[rd_addr];
			handler_s1 <= handler_mem[rd_addr];
			runs_s1    <= runs_mem[rd_addr];
			base_s1    <= base_mem[rd_addr];
			ev_idx_s1  <= rd_addr;
		end
	end

	assign ev_on     = ctl.scan && ev_v_s1;
	assign elapsed   = now_q - base_s1;
	assign base_sum  = base_s1 + {1'b0, period_s1};
	assign runs_inc  = runs_s1 + 16'd1;
	assign unlimited = limit_s1 == 16'd0;
	assign ev_due    = ev_on && used_q[ev_idx_s1] && (elapsed >= {1'b0, period_s1});
	assign ev_fire   = ev_due && en_q[ev_idx_s1] && (unlimited || runs_s1 < limit_s1);
	assign ev_last   = ev_fire && !unlimited && (runs_inc >= limit_s1);

	assign sts.is_tick   = cmd_t'(cmd) == CMD_TICK;
	assign sts.scan_done = ev_on && (ev_idx_s1 == IW'(SLOTS - 1) ||
		(ev_fire && fire_cnt_q == FIRE_W'(MAX_RESULTS - 1)));

	always_comb begin
		used_d    = used_q;
		en_d      = en_q;
		cnt_d     = cnt_q;
		waddr     = ev_idx_s1;
		we_cfg    = 1'b0;
		we_runs   = 1'b0;
		we_base   = 1'b0;
		wd_runs   = runs_inc;
		wd_base   = base_sum;
		emit      = 1'b0;
		e_kind    = KIND_ACK;
		e_slot    = '0;
		e_handler = '0;
		e_freed   = 1'b0;
		e_status  = STAT_OK;
		e_en      = 1'b0;
		e_count   = cnt_q;
		e_last    = 1'b1;
		if (ctl.exec) begin
			emit = 1'b1;
			case (cmd_q)
				CMD_SET: begin
					if (!any_free) begin
						e_status = STAT_NOFREE;
					end else if (handler_q == 8'd0) begin
						e_status = STAT_NULL;
					end else begin
						waddr            = free_idx;
						we_cfg           = 1'b1;
						we_runs          = 1'b1;
						we_base          = 1'b1;
						wd_runs          = '0;
						wd_base          = now_q;
						used_d[free_idx] = 1'b1;
						en_d[free_idx]   = 1'b1;
						cnt_d            = cnt_q + 7'd1;
						e_slot           = 6'(free_idx);
					end
				end
				default: begin
					e_slot = slot_q;
					if (!in_range) begin
						e_status = STAT_RANGE;
					end else begin
						case (cmd_q)
							CMD_DELETE: begin
								if (used_q[tgt]) begin
									used_d[tgt] = 1'b0;
									en_d[tgt]   = 1'b0;
									cnt_d       = cnt_q - 7'd1;
								end
							end
							CMD_RESTART: begin
								waddr   = tgt;
								we_base = 1'b1;
								wd_base = now_q;
							end
							CMD_ENABLE:  en_d[tgt] = 1'b1;
							CMD_DISABLE: en_d[tgt] = 1'b0;
							CMD_TOGGLE:  en_d[tgt] = !en_q[tgt];
							CMD_QUERY:   e_en = en_q[tgt];
							default: e_en = 1'b0;
						endcase
					end
				end
			endcase
			e_count = cnt_d;
		end else if (ev_on) begin
			we_base = ev_due;
			we_runs = ev_fire && !unlimited;
			if (ev_last) begin
				used_d[ev_idx_s1] = 1'b0;
				en_d[ev_idx_s1]   = 1'b0;
				cnt_d             = cnt_q - 7'd1;
			end
			// A new firing releases the one held back, which is then not the last.
			if (ev_fire && pend_v_q) begin
				emit      = 1'b1;
				e_kind    = KIND_FIRED;
				e_slot    = 6'(pend_slot_q);
				e_handler = pend_handler_q;
				e_freed   = pend_freed_q;
				e_count   = pend_count_q;
				e_last    = 1'b0;
			end
		end else if (ctl.flush) begin
			emit = 1'b1;
			if (pend_v_q) begin
				e_kind    = KIND_FIRED;
				e_slot    = 6'(pend_slot_q);
				e_handler = pend_handler_q;
				e_freed   = pend_freed_q;
				e_count   = pend_count_q;
			end else begin
				e_kind = KIND_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			en_q       <= '0;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			ev_v_s1    <= 1'b0;
			fire_cnt_q <= '0;
			pend_v_q   <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			used_q  <= used_d;
			en_q    <= en_d;
			cnt_q   <= cnt_d;
			valid_q <= emit;
			if (ctl.load) begin
				rd_idx_q   <= '0;
				ev_v_s1    <= 1'b0;
				fire_cnt_q <= '0;
				pend_v_q   <= 1'b0;
			end else if (ctl.scan) begin
				ev_v_s1 <= rd_more;
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (ev_fire) begin
					fire_cnt_q <= fire_cnt_q + FIRE_W'(1);
					pend_v_q   <= 1'b1;
				end
			end else if (ctl.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_fire) begin
			pend_slot_q    <= ev_idx_s1;
			pend_handler_q <= handler_s1;
			pend_freed_q   <= ev_last;
			pend_count_q   <= cnt_d;
		end
		if (emit) begin
			kind_q        <= e_kind;
			out_slot_q    <= e_slot;
			out_handler_q <= e_handler;
			freed_q       <= e_freed;
			status_q      <= e_status;
			en_out_q      <= e_en;
			count_q       <= e_count;
			last_q        <= e_last;
		end
	end

	assign res_valid    = valid_q;
	assign kind         = kind_q;
	assign out_slot     = out_slot_q;
	assign out_handler  = out_handler_q;
	assign freed        = freed_q;
	assign status       = status_q;
	assign is_enabled   = en_out_q;
	assign active_count = count_q;
	assign last         = last_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 7'($countones(used_q)))
		else $error("occupied count differs from the occupancy flags");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_W'(MAX_RESULTS))
		else $error("more firings in one tick than allowed");

endmodule

/* hdl/multi_slot_software_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_software_timer: table of periodic and one-shot timer slots
// Manages SLOTS timer slots by command and reports firings on each tick.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------------
//  command  | start / busy       | cmd, now_ms, slot, period_ms, run_limit, handler
//  result   | valid (one cycle)  | kind, out_slot, out_handler, freed, status,
//           |                    | is_enabled, active_count, last
//
// A word is accepted at a clock edge with start high and busy low. A
// single-slot command is latched and then executed; its acknowledgement
// shows in the cycle after the execution. In a tick the scan reads one slot
// per cycle from the slot tables (one read port) and evaluates it in the
// following cycle, and it ends early once MAX_RESULTS slots have fired. Each
// firing is held back one step so that the final word of a tick carries
// last. Results cannot be stalled: each stands on the ports for one cycle
// with valid high. Reset clears all slots at once through the occupancy
// flags; there is no clearing pass.
//
module multi_slot_software_timer import mst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [5:0]  slot,
	input  logic [30:0] period_ms,
	input  logic [15:0] run_limit,
	input  logic [7:0]  handler,
	output logic        valid,
	output logic [1:0]  kind,
	output logic [5:0]  out_slot,
	output logic [7:0]  out_handler,
	output logic        freed,
	output logic [1:0]  status,
	output logic        is_enabled,
	output logic [6:0]  active_count,
	output logic        last
);

	// The controller only steps through the phases of a word; every slot
	// access, count update and result register lives in the datapath.
	ctl_t ctl;
	sts_t sts;

	mst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	mst_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.now_ms       (now_ms),
		.slot         (slot),
		.period_ms    (period_ms),
		.run_limit    (run_limit),
		.handler      (handler),
		.res_valid    (valid),
		.kind         (kind),
		.out_slot     (out_slot),
		.out_handler  (out_handler),
		.freed        (freed),
		.status       (status),
		.is_enabled   (is_enabled),
		.active_count (active_count),
		.last         (last)
	);

	// When the block goes idle, the final word of the item is on the ports.
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && last)
		else $error("item finished without its final word");

	// A word that is not the last is always followed by more of the same item.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("intermediate word while idle");

	// No word appears while the block stands idle.
	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy || $fell(busy))
		else $error("result word with no item in progress");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_slot_software_timer
// Drives command words through the start/busy handshake in bursts with random
// gaps, keeps a shadow copy of the timer table to predict every result word,
// and compares each strobed result field by field against the oldest
// prediction. Directed cases cover the field extremes, every command and the
// corner cases; a full-table test and a long run of random traffic follow.
// ----------------------------------------------------------------------------
module testbench;
	import mst_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int NSLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	// One predicted result word, laid out like the result ports.
	typedef struct packed {
		kind_t      kind;
		logic [5:0] slot;
		logic [7:0] handler;
		logic       freed;
		status_t    status;
		logic       en;
		logic [6:0] active;
		logic       last;
	} timer_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [31:0] now_ms;
	logic [5:0]  slot;
	logic [30:0] period_ms;
	logic [15:0] run_limit;
	logic [7:0]  handler;
	logic        valid;
	logic [1:0]  kind;
	logic [5:0]  out_slot;
	logic [7:0]  out_handler;
	logic        freed;
	logic [1:0]  status;
	logic        is_enabled;
	logic [6:0]  active_count;
	logic        last;

	// Shadow copy of the timer table.
	logic        tbl_used    [NSLOT];
	logic        tbl_enabled [NSLOT];
	logic [30:0] tbl_period  [NSLOT];
	logic [7:0]  tbl_handler [NSLOT];
	logic [15:0] tbl_limit   [NSLOT];
	logic [15:0] tbl_runs    [NSLOT];
	logic [31:0] tbl_base    [NSLOT];
	int          tbl_count;

	timer_word_t expected_words[$];
	int          error_count;
	int          burst_left;
	logic [31:0] clock_ms;

	multi_slot_software_timer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.now_ms       (now_ms),
		.slot         (slot),
		.period_ms    (period_ms),
		.run_limit    (run_limit),
		.handler      (handler),
		.valid        (valid),
		.kind         (kind),
		.out_slot     (out_slot),
		.out_handler  (out_handler),
		.freed        (freed),
		.status       (status),
		.is_enabled   (is_enabled),
		.active_count (active_count),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake or the result stream hangs.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Clearing a slot also resets its handler, period and run count.
	task automatic release_slot(input int i);
		if (tbl_used[i]) begin
			tbl_used[i] = 1'b0;
			tbl_enabled[i] = 1'b0;
			tbl_handler[i] = '0;
			tbl_period[i] = '0;
			tbl_runs[i] = '0;
			if (tbl_count > 0)
				tbl_count--;
		end
	endtask

	// Applies one accepted word to the shadow table and queues the result
	// words it must produce, in order, with last on the final one.
	task automatic predict_timer_words(input cmd_t c, input logic [31:0] now,
			input logic [5:0] s, input logic [30:0] per, input logic [15:0] lim,
			input logic [7:0] h);
		timer_word_t w;
		timer_word_t batch[$];
		int i;
		int fired;
		int found;
		logic fire;
		logic last_run;
		logic [NSLOT_W-1:0] si;
		if (c == CMD_TICK) begin
			fired = 0;
			for (i = 0; i < NSLOT && fired < MAX_RESULTS; i++) begin
				if (!tbl_used[i])
					continue;
				if ((now - tbl_base[i]) < 32'(tbl_period[i]))
					continue;
				// A due slot always moves on by one period, enabled or not.
				tbl_base[i] = tbl_base[i] + 32'(tbl_period[i]);
				if (!tbl_enabled[i])
					continue;
				fire = 1'b0;
				last_run = 1'b0;
				if (tbl_limit[i] == 16'd0) begin
					fire = 1'b1;
				end else if (tbl_runs[i] < tbl_limit[i]) begin
					fire = 1'b1;
					tbl_runs[i]++;
					if (tbl_runs[i] >= tbl_limit[i])
						last_run = 1'b1;
				end
				if (fire) begin
					w = '0;
					w.kind = KIND_FIRED;
					w.slot = 6'(i);
					w.handler = tbl_handler[i];
					w.freed = last_run;
					if (last_run)
						release_slot(i);
					w.active = 7'(tbl_count);
					batch.push_back(w);
					fired++;
				end
			end
			if (batch.size() == 0) begin
				w = '0;
				w.kind = KIND_IDLE;
				w.active = 7'(tbl_count);
				batch.push_back(w);
			end
		end else if (c == CMD_SET) begin
			w = '0;
			w.kind = KIND_ACK;
			found = -1;
			if (tbl_count < NSLOT) begin
				for (i = NSLOT - 1; i >= 0; i--)
					if (!tbl_used[i])
						found = i;
			end
			// A full table is reported ahead of a null handler.
			if (found < 0) begin
				w.status = STAT_NOFREE;
			end else if (h == 8'd0) begin
				w.status = STAT_NULL;
			end else begin
				tbl_used[found] = 1'b1;
				tbl_enabled[found] = 1'b1;
				tbl_period[found] = per;
				tbl_handler[found] = h;
				tbl_limit[found] = lim;
				tbl_base[found] = now;
				tbl_count++;
				w.slot = 6'(found);
				w.status = STAT_OK;
			end
			w.active = 7'(tbl_count);
			batch.push_back(w);
		end else begin
			w = '0;
			w.kind = KIND_ACK;
			w.slot = s;
			if (s >= NSLOT) begin
				w.status = STAT_RANGE;
			end else begin
				w.status = STAT_OK;
				si = s[NSLOT_W-1:0];
				// Free slots are written too; a later set overwrites them.
				case (c)
					CMD_DELETE:  release_slot(int'(si));
					CMD_RESTART: tbl_base[si] = now;
					CMD_ENABLE:  tbl_enabled[si] = 1'b1;
					CMD_DISABLE: tbl_enabled[si] = 1'b0;
					CMD_TOGGLE:  tbl_enabled[si] = !tbl_enabled[si];
					default:     w.en = tbl_enabled[si];
				endcase
			end
			w.active = 7'(tbl_count);
			batch.push_back(w);
		end
		w = batch.pop_back();
		w.last = 1'b1;
		batch.push_back(w);
		while (batch.size() != 0)
			expected_words.push_back(batch.pop_front());
	endtask

	// Offers one word at the falling edge and holds it until an edge with
	// busy low takes it. Bursts end with a random pause on start.
	task automatic send_word(input cmd_t c, input logic [31:0] now,
			input logic [5:0] s, input logic [30:0] per, input logic [15:0] lim,
			input logic [7:0] h);
		logic taken;
		start = 1'b1;
		cmd = c;
		now_ms = now;
		slot = s;
		period_ms = per;
		run_limit = lim;
		handler = h;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			if (taken)
				predict_timer_words(c, now, s, per, lim, h);
			@(negedge clk);
		end
		burst_left--;
		if (burst_left <= 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			// Now and then a long burst with no idling at all.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name,
				want, got);
			error_count++;
		end
	endfunction

	// Result checker: every strobed word is matched against the oldest
	// prediction. Outputs are read at the rising edge before they update.
	always @(posedge clk) begin
		timer_word_t want;
		if (arst_n && valid) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word: expected none, actual kind %0d slot %0d",
					$time, kind, out_slot);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				check_field("kind", want.kind, kind);
				check_field("out_slot", want.slot, out_slot);
				check_field("out_handler", want.handler, out_handler);
				check_field("freed", want.freed, freed);
				check_field("status", want.status, status);
				check_field("is_enabled", want.en, is_enabled);
				check_field("active_count", want.active, active_count);
				check_field("last", want.last, last);
			end
		end
	end

	// Field extremes, every command, wrap of the time, disabled and free
	// slots, out-of-range slots and a null handler.
	task automatic test_directed_cases();
		send_word(CMD_TICK, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_SET, 32'd0, 6'd63, 31'h7FFF_FFFF, 16'hFFFF, 8'd0);
		send_word(CMD_SET, 32'd0, 6'(($urandom)), 31'd0, 16'd0, 8'd255);
		send_word(CMD_SET, 32'hFFFF_FFFF, 6'd0, 31'h7FFF_FFFF, 16'hFFFF, 8'd1);
		send_word(CMD_SET, 32'd100, 6'd0, 31'd10, 16'd1, 8'h5A);
		send_word(CMD_SET, 32'd100, 6'd0, 31'd3, 16'd2, 8'hA5);
		send_word(CMD_TICK, 32'd105, 6'(($urandom)), 31'(($urandom)), 16'(($urandom)), 8'd0);
		// The one-shot and the two-run timer both end on this tick.
		send_word(CMD_TICK, 32'd110, 6'd0, 31'd0, 16'd0, 8'd0);
		// Difference across the wrap equals the largest period exactly.
		send_word(CMD_TICK, 32'h7FFF_FFFE, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_QUERY, 32'd0, 6'd63, 31'd0, 16'd0, 8'd0);
		send_word(CMD_DELETE, 32'd0, 6'(NSLOT), 31'd0, 16'd0, 8'd0);
		send_word(CMD_DISABLE, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_TICK, 32'h7FFF_FFFF, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_QUERY, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_TOGGLE, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_QUERY, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_RESTART, 32'h8000_0000, 6'd1, 31'd0, 16'd0, 8'd0);
		send_word(CMD_TOGGLE, 32'd0, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_RESTART, 32'd123, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_QUERY, 32'd0, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_DELETE, 32'd0, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_ENABLE, 32'd0, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_QUERY, 32'd0, 6'd5, 31'd0, 16'd0, 8'd0);
		send_word(CMD_DELETE, 32'd0, 6'd1, 31'd0, 16'd0, 8'd0);
		send_word(CMD_DELETE, 32'd0, 6'd0, 31'd0, 16'd0, 8'd0);
	endtask

	// Fills every slot, refuses further sets, and fires all slots in one
	// tick, the most firings a tick can report; then frees them all at once.
	task automatic test_full_table();
		int i;
		for (i = 0; i < NSLOT; i++)
			send_word(CMD_DELETE, clock_ms, 6'(i), 31'(($urandom)), 16'(($urandom)), 8'(($urandom)));
		for (i = 0; i < NSLOT; i++)
			send_word(CMD_SET, clock_ms, 6'(($urandom)), 31'd0, 16'd0,
				8'($urandom_range(1, 255)));
		send_word(CMD_SET, clock_ms, 6'd0, 31'd5, 16'd3, 8'($urandom_range(1, 255)));
		send_word(CMD_SET, clock_ms, 6'd0, 31'd5, 16'd3, 8'd0);
		clock_ms = clock_ms + 32'd1;
		send_word(CMD_TICK, clock_ms, 6'd0, 31'd0, 16'd0, 8'd0);
		send_word(CMD_DISABLE, clock_ms, 6'd3, 31'd0, 16'd0, 8'd0);
		clock_ms = clock_ms + 32'd1;
		send_word(CMD_TICK, clock_ms, 6'd0, 31'd0, 16'd0, 8'd0);
		for (i = 0; i < NSLOT; i++)
			send_word(CMD_DELETE, clock_ms, 6'(i), 31'd0, 16'd0, 8'd0);
		for (i = 0; i < NSLOT; i++)
			send_word(CMD_SET, clock_ms, 6'd0, 31'd0, 16'd1, 8'($urandom_range(1, 255)));
		send_word(CMD_TICK, clock_ms, 6'd0, 31'd0, 16'd0, 8'd0);
	endtask

	// Mostly a running clock with short periods and small run limits so that
	// slots fill, fire, expire and get reused; occasional full-width values,
	// out-of-range slots, null handlers and jumps of the time as noise.
	task automatic test_random_traffic(input int count);
		int n;
		int pick;
		cmd_t c;
		logic [5:0] s;
		logic [30:0] per;
		logic [15:0] lim;
		logic [7:0] h;
		clock_ms = 32'hFFFF_FE00 + 32'($urandom_range(0, 255));
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			s = 6'($urandom_range(0, NSLOT - 1));
			if ($urandom_range(0, 9) == 0)
				s = 6'($urandom);
			per = 31'($urandom_range(0, 24));
			if ($urandom_range(0, 19) == 0)
				per = 31'($urandom);
			lim = 16'($urandom_range(0, 4));
			if ($urandom_range(0, 9) == 0)
				lim = 16'($urandom);
			h = 8'($urandom_range(1, 255));
			if ($urandom_range(0, 14) == 0)
				h = 8'd0;
			if (pick < 38) begin
				c = CMD_TICK;
				clock_ms = clock_ms + 32'($urandom_range(0, 12));
			end else if (pick < 58) begin
				c = CMD_SET;
			end else if (pick < 66) begin
				c = CMD_DELETE;
			end else if (pick < 72) begin
				c = CMD_RESTART;
			end else if (pick < 78) begin
				c = CMD_ENABLE;
			end else if (pick < 84) begin
				c = CMD_DISABLE;
			end else if (pick < 90) begin
				c = CMD_TOGGLE;
			end else begin
				c = CMD_QUERY;
			end
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom;
			send_word(c, clock_ms, s, per, lim, h);
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_TICK;
		now_ms = '0;
		slot = '0;
		period_ms = '0;
		run_limit = '0;
		handler = '0;
		error_count = 0;
		burst_left = 1;
		clock_ms = '0;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_enabled[i] = 1'b0;
			tbl_period[i] = '0;
			tbl_handler[i] = '0;
			tbl_limit[i] = '0;
			tbl_runs[i] = '0;
			tbl_base[i] = '0;
		end
		tbl_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_full_table();
		test_random_traffic(280);
		start = 1'b0;

		// Drain what is still in flight, then allow for one full tick scan.
		waited = 0;
		while (expected_words.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (NSLOT + 8) @(posedge clk);
		if (expected_words.size() != 0) begin
			$display("%0t: result words missing: expected %0d more, actual 0", $time,
				expected_words.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
hdl/mst_pkg.sv
hdl/mst_ctrl.sv
hdl/mst_dpath.sv
hdl/multi_slot_software_timer.sv
sim/testbench.sv
